FILE: rtl/u128d_pkg.sv
`timescale 1ns / 1ps
// u128d_pkg: shared constants, the job record and small tables for the
// 128-bit binary to decimal converter. No dependencies.
package u128d_pkg;

	localparam int unsigned DIGIT_DEPTH = 39;
	localparam int unsigned COUNT_W     = 6;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned LIMB_W      = 32;
	localparam int unsigned N_LIMBS     = 4;
	localparam int unsigned LIMB_IDX_W  = 2;

	// x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
	localparam logic [LIMB_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int unsigned       RECIP_SHIFT = 35;

	typedef struct packed {
		logic [63:0]           value_high;
		logic [63:0]           value_low;
		logic [LIMB_IDX_W-1:0] top_limb;
	} job_t;

	// r * floor(2^32 / 10), r being a remainder 0..9
	function automatic logic [LIMB_W-1:0] limb_scale(input logic [DIGIT_W-1:0] r);
		logic [LIMB_W-1:0] v;
		case (r)
			4'd0: v = 32'd0;
			4'd1: v = 32'd429496729;
			4'd2: v = 32'd858993458;
			4'd3: v = 32'd1288490187;
			4'd4: v = 32'd1717986916;
			4'd5: v = 32'd2147483645;
			4'd6: v = 32'd2576980374;
			4'd7: v = 32'd3006477103;
			4'd8: v = 32'd3435973832;
			4'd9: v = 32'd3865470561;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// quotient by ten of a value below 64
	function automatic logic [2:0] small_div10(input logic [5:0] t);
		logic [2:0] q;
		if (t >= 6'd60) q = 3'd6;
		else if (t >= 6'd50) q = 3'd5;
		else if (t >= 6'd40) q = 3'd4;
		else if (t >= 6'd30) q = 3'd3;
		else if (t >= 6'd20) q = 3'd2;
		else if (t >= 6'd10) q = 3'd1;
		else q = 3'd0;
		return q;
	endfunction

endpackage

FILE: rtl/u128d_if.sv
`timescale 1ns / 1ps
// u128d channel interfaces: value channel in, digit channel out.
// Depends on u128d_pkg for the digit width.
interface u128d_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_high;
	logic [63:0] value_low;

	modport source (output valid, output value_high, output value_low, input ready);
	modport sink   (input valid, input value_high, input value_low, output ready);
endinterface

interface u128d_out_if;
	logic                            valid;
	logic                            ready;
	logic [u128d_pkg::DIGIT_W-1:0]   digit;
	logic                            last;

	modport source (output valid, output digit, output last, input ready);
	modport sink   (input valid, input digit, input last, output ready);
endinterface

FILE: rtl/u128_to_decimal_digits.sv
`timescale 1ns / 1ps
// u128_to_decimal_digits: top level of the 128-bit binary to decimal converter.
// Depends on u128d_pkg, u128d_if, u128d_front and u128d_back.
//
// value_ch (sink) takes one unsigned 128-bit value per beat as value_high and
// value_low. digit_ch (source) gives its decimal digits, most significant
// first, one per beat, with no leading zeros; last marks the final digit.
// a value of zero gives the single digit 0
//
// the front holds up to two values, tagged with their highest non-zero limb.
// the back divides by ten one 32-bit limb per cycle, starting each digit at
// the highest non-zero limb of the running quotient. that limb step (one
// 32x32 reciprocal multiply) sets the rate. once division ends, digits
// stream out at one per cycle while the receiver is ready. the back returns
// to idle once the last store read is issued, and only then takes the next
// value and starts its division
//
// reset empties both queues and returns the back to idle; no digit beat is
// offered until a value has been converted. when the receiver stalls, the
// two-entry output queue fills, playback pauses, and the front still takes
// up to two further values before deasserting ready
module u128_to_decimal_digits (
	input  logic        clk,
	input  logic        arst_n,
	u128d_in_if.sink    value_ch,
	u128d_out_if.source digit_ch
);

	// job handed from the classifying front to the dividing back
	u128d_pkg::job_t job;
	logic            job_valid;
	logic            job_ready;

	u128d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.value_ch  (value_ch),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready)
	);

	u128d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.digit_ch  (digit_ch)
	);

endmodule

FILE: rtl/u128d_front.sv
`timescale 1ns / 1ps
// u128d_front: takes value beats, finds the highest non-zero 32-bit limb and
// holds up to two jobs for the back end. Depends on u128d_pkg, u128d_if.
module u128d_front (
	input  logic                clk,
	input  logic                arst_n,
	u128d_in_if.sink            value_ch,
	output u128d_pkg::job_t     job,
	output logic                job_valid,
	input  logic                job_ready
);

	u128d_pkg::job_t q_mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;
	u128d_pkg::job_t in_job;

	always_comb begin
		in_job.value_high = value_ch.value_high;
		in_job.value_low  = value_ch.value_low;
		if (value_ch.value_high[63:32] != 32'd0) begin
			in_job.top_limb = 2'd3;
		end else if (value_ch.value_high[31:0] != 32'd0) begin
			in_job.top_limb = 2'd2;
		end else if (value_ch.value_low[63:32] != 32'd0) begin
			in_job.top_limb = 2'd1;
		end else begin
			in_job.top_limb = 2'd0;
		end
	end

	assign value_ch.ready = (cnt_q != 2'd2);
	assign push           = value_ch.valid & value_ch.ready;
	assign job_valid      = (cnt_q != 2'd0);
	assign pop            = job_valid & job_ready;
	assign job            = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= in_job;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("job queue count out of range");

endmodule

FILE: rtl/u128d_back.sv
`timescale 1ns / 1ps
// u128d_back: divides each job by ten one 32-bit limb per cycle, keeps the
// remainders in a digit store and plays them back most significant first.
// Depends on u128d_pkg, u128d_if.
module u128d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  u128d_pkg::job_t     job,
	input  logic                job_valid,
	output logic                job_ready,
	u128d_out_if.source         digit_ch
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic [u128d_pkg::DIGIT_W-1:0] digit;
		logic                          last;
	} beat_t;

	state_t                                state_q;
	logic [u128d_pkg::LIMB_W-1:0]          lim_q [u128d_pkg::N_LIMBS];
	logic [u128d_pkg::LIMB_IDX_W-1:0]      limb_idx_q;
	logic [u128d_pkg::DIGIT_W-1:0]         rem_q;
	logic [u128d_pkg::COUNT_W-1:0]         n_q;
	logic [u128d_pkg::COUNT_W-1:0]         rd_ptr_q;
	logic [u128d_pkg::DIGIT_W-1:0]         store_mem [u128d_pkg::DIGIT_DEPTH];
	logic [u128d_pkg::DIGIT_W-1:0]         rd_data_q;
	logic                                  rd_last_q;
	logic                                  rd_pend_q;
	beat_t                                 ofifo_q [2];
	logic                                  owr_q;
	logic                                  ord_q;
	logic [1:0]                            ocnt_q;

	logic [u128d_pkg::LIMB_W-1:0]          cur_limb;
	logic [63:0]                           prod;
	logic [28:0]                           q0;
	logic [u128d_pkg::LIMB_W-1:0]          q0x10;
	logic [u128d_pkg::DIGIT_W-1:0]         rem0;
	logic [5:0]                            t;
	logic [2:0]                            tq;
	logic [u128d_pkg::DIGIT_W-1:0]         new_rem;
	logic [u128d_pkg::LIMB_W-1:0]          new_limb;
	logic [u128d_pkg::LIMB_W-1:0]          nl [u128d_pkg::N_LIMBS];
	logic                                  quot_zero;
	logic [u128d_pkg::LIMB_IDX_W-1:0]      quot_top;
	logic                                  digit_end;
	logic                                  div_done;
	logic                                  take;
	logic                                  issue;
	logic                                  opop;

	// one limb step: (rem * 2^32 + limb) / 10
	assign cur_limb = lim_q[limb_idx_q];
	assign prod     = 64'(cur_limb) * 64'(u128d_pkg::RECIP_TEN);
	assign q0       = prod[63:u128d_pkg::RECIP_SHIFT];
	assign q0x10    = 32'({q0, 3'b000}) + 32'({q0, 1'b0});
	assign rem0     = 4'(cur_limb - q0x10);
	assign t        = 6'({rem_q, 2'b00}) + 6'({rem_q, 1'b0}) + 6'(rem0);
	assign tq       = u128d_pkg::small_div10(t);
	assign new_rem  = 4'(t - 6'({tq, 3'b000}) - 6'({tq, 1'b0}));
	assign new_limb = u128d_pkg::limb_scale(rem_q) + 32'(q0) + 32'(tq);

	always_comb begin
		for (int i = 0; i < int'(u128d_pkg::N_LIMBS); i++) begin
			nl[i] = lim_q[i];
		end
		nl[limb_idx_q] = new_limb;
	end

	always_comb begin
		quot_zero = 1'b0;
		if (nl[3] != 32'd0) quot_top = 2'd3;
		else if (nl[2] != 32'd0) quot_top = 2'd2;
		else if (nl[1] != 32'd0) quot_top = 2'd1;
		else begin
			quot_top  = 2'd0;
			quot_zero = (nl[0] == 32'd0);
		end
	end

	assign digit_end = (state_q == ST_DIV) && (limb_idx_q == 2'd0);
	assign div_done  = digit_end &&
		(quot_zero || (n_q == 6'(u128d_pkg::DIGIT_DEPTH - 1)));
	assign job_ready = (state_q == ST_IDLE);
	assign take      = job_valid & job_ready;

	// read ahead only while the output queue has room for the data in flight
	assign opop  = digit_ch.valid & digit_ch.ready;
	assign issue = (state_q == ST_EMIT) &&
		((3'(ocnt_q) + 3'(rd_pend_q)) < (3'd2 + 3'(opop)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			limb_idx_q <= '0;
			rem_q      <= '0;
			n_q        <= '0;
			rd_ptr_q   <= '0;
			rd_pend_q  <= 1'b0;
			owr_q      <= 1'b0;
			ord_q      <= 1'b0;
			ocnt_q     <= 2'd0;
		end else begin
			rd_pend_q <= issue;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						limb_idx_q <= job.top_limb;
						rem_q      <= '0;
						n_q        <= '0;
						state_q    <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (digit_end) begin
						rem_q      <= '0;
						limb_idx_q <= quot_top;
						n_q        <= n_q + 6'd1;
						if (div_done) begin
							rd_ptr_q <= n_q;
							state_q  <= ST_EMIT;
						end
					end else begin
						rem_q      <= new_rem;
						limb_idx_q <= limb_idx_q - 2'd1;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						rd_ptr_q <= rd_ptr_q - 6'd1;
						if (rd_ptr_q == 6'd0) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (rd_pend_q) owr_q <= ~owr_q;
			if (opop) ord_q <= ~ord_q;
			if (rd_pend_q && !opop) ocnt_q <= ocnt_q + 2'd1;
			else if (opop && !rd_pend_q) ocnt_q <= ocnt_q - 2'd1;
		end
	end

	// datapath registers and the digit store
	always_ff @(posedge clk) begin
		if (take) begin
			lim_q[3] <= job.value_high[63:32];
			lim_q[2] <= job.value_high[31:0];
			lim_q[1] <= job.value_low[63:32];
			lim_q[0] <= job.value_low[31:0];
		end else if (state_q == ST_DIV) begin
			lim_q[limb_idx_q] <= new_limb;
		end
		if (digit_end) store_mem[n_q] <= new_rem;
		if (issue) begin
			rd_data_q <= store_mem[rd_ptr_q];
			rd_last_q <= (rd_ptr_q == 6'd0);
		end
		if (rd_pend_q) begin
			ofifo_q[owr_q].digit <= rd_data_q;
			ofifo_q[owr_q].last  <= rd_last_q;
		end
	end

	assign digit_ch.valid = (ocnt_q != 2'd0);
	assign digit_ch.digit = ofifo_q[ord_q].digit;
	assign digit_ch.last  = ofifo_q[ord_q].last;

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> rd_ptr_q < 6'(u128d_pkg::DIGIT_DEPTH))
		else $error("digit store read beyond its depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (ocnt_q != 2'd2) || opop)
		else $error("output queue overflow");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_ch.valid |-> digit_ch.digit <= 4'd9)
		else $error("digit out of range");

	a_take_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q == ST_DIV)
		else $error("job taken without starting division");

	a_cap_ends_div: assert property (@(posedge clk) disable iff (!arst_n)
		digit_end && n_q == 6'(u128d_pkg::DIGIT_DEPTH - 1) |=> state_q == ST_EMIT)
		else $error("division ran past the digit cap");

endmodule
